// ----- src/cbse_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// cbse_pkg: shared constants and types of the cubic B-spline evaluator
// Store geometry, fixed-point widths, register indexes and reset values.
// ----------------------------------------------------------------------------
package cbse_pkg;

  // Coefficient store geometry.
  localparam int NUM_COEFFS = 16;
  localparam int COEF_AW    = (NUM_COEFFS > 1) ? $clog2(NUM_COEFFS) : 1;
  localparam int TAPS       = 4;

  // Fixed-point widths (Q8.16 data, unsigned Q.16 weights).
  localparam int COEF_W = 24;
  localparam int WGT_W  = 20;
  localparam int PROD_W = COEF_W + WGT_W + 1;

  localparam logic [16:0] Q_ONE = 17'h10000;

  // Register indexes, taken from paddr[3:2].
  localparam logic [1:0] REG_KNOT_ORIGIN = 2'd0;
  localparam logic [1:0] REG_KNOT_STEP   = 2'd1;
  localparam logic [1:0] REG_INV_STEP    = 2'd2;

  // Register reset values.
  localparam logic [23:0] KNOT_ORIGIN_RST = 24'hFB0000;
  localparam logic [22:0] KNOT_STEP_RST   = 23'd50412;
  localparam logic [22:0] INV_STEP_RST    = 23'd85197;

  // Output saturation limits.
  localparam logic [23:0] SAT_MAX = 24'h7FFFFF;
  localparam logic [23:0] SAT_MIN = 24'h800000;

  typedef logic signed [COEF_W-1:0] coef_t;
  typedef logic        [WGT_W-1:0]  wgt_t;
  typedef logic signed [PROD_W-1:0] prod_t;

endpackage : cbse_pkg
`default_nettype wire

// ----- src/cbse_ram.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// cbse_ram: generic single-write, single-read RAM
// One write port and one read port with a registered, enabled read.
// ----------------------------------------------------------------------------
module cbse_ram #(
  parameter  int WIDTH = 24,
  parameter  int DEPTH = 16,
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic             re,
  input  wire logic [AW-1:0]    raddr,
  output      logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule : cbse_ram
`default_nettype wire

// ----- src/cubic_bspline_evaluator.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// cubic_bspline_evaluator: uniform cubic B-spline evaluation in Q8.16
// Loads coefficients into a store and evaluates the spline at given points.
// ----------------------------------------------------------------------------
// An evaluate beat passes through stages A to G and the output register in
// order. Throughput: one beat per cycle, load or evaluate, unless out_tready
// stalls the chain; the eight register stages each hold one beat and stall
// independently, so bubbles are squeezed out.
// Reset (rst_n low at a clock edge) empties every stage and restores the
// register reset values; the coefficient store is not cleared.
// ----------------------------------------------------------------------------
module cubic_bspline_evaluator
  import cbse_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  // Input stream.
  input  wire logic        in_tvalid,
  output      logic        in_tready,
  // [3:0] coeff_index, [27:4] coeff_value, [51:28] x_value, [55:52] zero
  input  wire logic [55:0] in_tdata,
  // [0] action (0 load, 1 evaluate)
  input  wire logic [0:0]  in_tuser,
  // Result stream.
  output      logic        out_tvalid,
  input  wire logic        out_tready,
  // [23:0] spline_value
  output      logic [23:0] out_tdata,
  // [0] in_support
  output      logic [0:0]  out_tuser,
  // Configuration port.
  input  wire logic        cfg_psel,
  input  wire logic        cfg_penable,
  input  wire logic        cfg_pwrite,
  input  wire logic [3:0]  cfg_paddr,
  input  wire logic [31:0] cfg_pwdata,
  output      logic [31:0] cfg_prdata,
  output      logic        cfg_pready
);

  // --------------------------------------------------------------------------
  // Configuration registers. Writes complete in the access phase; pready is
  // tied high so every access finishes without wait states.
  // --------------------------------------------------------------------------
  logic [23:0] knot_origin_r;
  logic [22:0] knot_step_r;
  logic [22:0] inv_step_r;
  logic        cfg_wr;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      knot_origin_r <= KNOT_ORIGIN_RST;
      knot_step_r   <= KNOT_STEP_RST;
      inv_step_r    <= INV_STEP_RST;
    end else if (cfg_wr) begin
      case (cfg_paddr[3:2])
        REG_KNOT_ORIGIN: knot_origin_r <= cfg_pwdata[23:0];
        REG_KNOT_STEP:   knot_step_r   <= cfg_pwdata[22:0];
        REG_INV_STEP:    inv_step_r    <= cfg_pwdata[22:0];
        default: ;
      endcase
    end
  end

  // Reads return the register value; the origin is sign-extended.
  always_comb begin
    case (cfg_paddr[3:2])
      REG_KNOT_ORIGIN: cfg_prdata = {{8{knot_origin_r[23]}}, knot_origin_r};
      REG_KNOT_STEP:   cfg_prdata = {9'd0, knot_step_r};
      REG_INV_STEP:    cfg_prdata = {9'd0, inv_step_r};
      default:         cfg_prdata = 32'd0;
    endcase
  end

  // --------------------------------------------------------------------------
  // Stage enables. A stage may load when it is empty or its content moves on,
  // so the chain runs from the output register back to the input.
  // --------------------------------------------------------------------------
  logic a_v_r, b_v_r, c_v_r, d_v_r, e_v_r, f_v_r, g_v_r, o_v_r;
  logic en_a, en_b, en_c, en_d, en_e, en_f, en_g, en_o;
  logic b_eval_r;

  assign en_o = !o_v_r || out_tready;
  assign en_g = !g_v_r || en_o;
  assign en_f = !f_v_r || en_g;
  assign en_e = !e_v_r || en_f;
  assign en_d = !d_v_r || en_e;
  assign en_c = !c_v_r || en_d;
  assign en_b = !b_v_r || en_c;
  assign en_a = !a_v_r || en_b;

  assign in_tready = en_a;

  // Load beats travel through stages A and B and write the store as they
  // leave B, the same point at which an evaluate beat reads it. This keeps
  // reads and writes in the order the beats arrived. Only evaluate beats
  // continue past B.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_v_r <= 1'b0;
      b_v_r <= 1'b0;
      c_v_r <= 1'b0;
      d_v_r <= 1'b0;
      e_v_r <= 1'b0;
      f_v_r <= 1'b0;
      g_v_r <= 1'b0;
      o_v_r <= 1'b0;
    end else begin
      if (en_a) a_v_r <= in_tvalid;
      if (en_b) b_v_r <= a_v_r;
      if (en_c) c_v_r <= b_v_r && b_eval_r;
      if (en_d) d_v_r <= c_v_r;
      if (en_e) e_v_r <= d_v_r;
      if (en_f) f_v_r <= e_v_r;
      if (en_g) g_v_r <= f_v_r;
      if (en_o) o_v_r <= g_v_r;
    end
  end

  // --------------------------------------------------------------------------
  // Stage A: offset from the first knot, d = x - origin (25 bits signed).
  // --------------------------------------------------------------------------
  logic              a_eval_r;
  logic [3:0]        a_idx_r;
  coef_t             a_coef_r;
  logic signed [24:0] a_d_r;
  logic signed [24:0] a_d_nxt;

  assign a_d_nxt = $signed({in_tdata[51], in_tdata[51:28]})
                 - $signed({knot_origin_r[23], knot_origin_r});

  always_ff @(posedge clk) begin
    if (en_a) begin
      a_eval_r <= in_tuser[0];
      a_idx_r  <= in_tdata[3:0];
      a_coef_r <= in_tdata[27:4];
      a_d_r    <= a_d_nxt;
    end
  end

  // --------------------------------------------------------------------------
  // Stage B: t = d * inv_step in Q.32. The integer part is the interval j,
  // bits 31..16 the fraction u.
  // --------------------------------------------------------------------------
  logic [3:0]        b_idx_r;
  coef_t             b_coef_r;
  logic signed [15:0] b_j_r;
  logic [15:0]       b_u_r;
  logic signed [48:0] b_t_nxt;

  assign b_t_nxt = a_d_r * $signed({1'b0, inv_step_r});

  always_ff @(posedge clk) begin
    if (en_b) begin
      b_eval_r <= a_eval_r;
      b_idx_r  <= a_idx_r;
      b_coef_r <= a_coef_r;
      b_j_r    <= b_t_nxt[47:32];
      b_u_r    <= b_t_nxt[31:16];
    end
  end

  // --------------------------------------------------------------------------
  // Store access. Four copies of the store are written together so that the
  // four coefficients j..j+3 are read together. Read data lines up with
  // stage C.
  // --------------------------------------------------------------------------
  logic [16:0]        k_idx   [TAPS];
  logic [TAPS-1:0]    k_ok;
  logic [COEF_AW-1:0] rd_addr [TAPS];
  logic [31:0]        wr_idx_ext;
  logic               ram_we;
  coef_t              ram_q   [TAPS];
  logic               sup_nxt;

  always_comb begin
    for (int n = 0; n < TAPS; n++) begin
      k_idx[n]   = {b_j_r[15], b_j_r} + 17'(n);
      k_ok[n]    = !k_idx[n][16] && (32'(k_idx[n]) < NUM_COEFFS);
      rd_addr[n] = k_idx[n][COEF_AW-1:0];
    end
  end

  // The last tap only counts toward support when its weight can be nonzero.
  assign sup_nxt = k_ok[0] || k_ok[1] || k_ok[2] || (k_ok[3] && (b_u_r != 16'd0));

  assign wr_idx_ext = 32'(b_idx_r);
  assign ram_we     = en_c && b_v_r && !b_eval_r && (wr_idx_ext < NUM_COEFFS);

  for (genvar n = 0; n < TAPS; n++) begin : g_copy
    cbse_ram #(
      .WIDTH (COEF_W),
      .DEPTH (NUM_COEFFS)
    ) u_ram (
      .clk   (clk),
      .we    (ram_we),
      .waddr (wr_idx_ext[COEF_AW-1:0]),
      .wdata (b_coef_r),
      .re    (en_c),
      .raddr (rd_addr[n]),
      .rdata (ram_q[n])
    );
  end

  // --------------------------------------------------------------------------
  // Stage C: v = 1 - u and the full squares of u and v.
  // --------------------------------------------------------------------------
  logic [15:0]     c_u_r;
  logic [16:0]     c_vq_r;
  logic [31:0]     c_uu_r;
  logic [33:0]     c_vv_r;
  logic [TAPS-1:0] c_ok_r;
  logic            c_sup_r;
  logic [16:0]     c_v_nxt;

  assign c_v_nxt = Q_ONE - {1'b0, b_u_r};

  always_ff @(posedge clk) begin
    if (en_c) begin
      c_u_r   <= b_u_r;
      c_vq_r  <= c_v_nxt;
      c_uu_r  <= b_u_r * b_u_r;
      c_vv_r  <= 34'(c_v_nxt) * 34'(c_v_nxt);
      c_ok_r  <= k_ok;
      c_sup_r <= sup_nxt;
    end
  end

  // --------------------------------------------------------------------------
  // Stage D: cubes from the full squares, squares truncated to Q.16, and the
  // coefficients, with taps outside the store forced to zero.
  // --------------------------------------------------------------------------
  logic [15:0] d_u_r;
  logic [16:0] d_vq_r;
  logic [15:0] d_sq_u_r;
  logic [16:0] d_sq_v_r;
  logic [15:0] d_cube_u_r;
  logic [16:0] d_cube_v_r;
  coef_t       d_coef_r [TAPS];
  logic        d_sup_r;
  logic [47:0] uuu_nxt;
  logic [50:0] vvv_nxt;

  assign uuu_nxt = 48'(c_uu_r) * 48'(c_u_r);
  assign vvv_nxt = 51'(c_vv_r) * 51'(c_vq_r);

  always_ff @(posedge clk) begin
    if (en_d) begin
      d_u_r      <= c_u_r;
      d_vq_r     <= c_vq_r;
      d_sq_u_r   <= c_uu_r[31:16];
      d_sq_v_r   <= c_vv_r[32:16];
      d_cube_u_r <= uuu_nxt[47:32];
      d_cube_v_r <= vvv_nxt[48:32];
      d_sup_r    <= c_sup_r;
      for (int n = 0; n < TAPS; n++) begin
        d_coef_r[n] <= c_ok_r[n] ? ram_q[n] : '0;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Stage E: the four basis weights in unsigned Q.16. The middle pieces stay
  // positive, so plain unsigned arithmetic is safe.
  // --------------------------------------------------------------------------
  wgt_t        e_w_r [TAPS];
  coef_t       e_coef_r [TAPS];
  logic        e_sup_r;
  logic [20:0] w1_nxt;
  logic [20:0] w2_nxt;

  assign w1_nxt = 21'(Q_ONE) + 21'(d_vq_r) * 21'd3 + 21'(d_sq_v_r) * 21'd3
                - 21'(d_cube_v_r) * 21'd3;
  assign w2_nxt = 21'(Q_ONE) + 21'(d_u_r) * 21'd3 + 21'(d_sq_u_r) * 21'd3
                - 21'(d_cube_u_r) * 21'd3;

  always_ff @(posedge clk) begin
    if (en_e) begin
      e_w_r[0] <= WGT_W'(d_cube_v_r);
      e_w_r[1] <= w1_nxt[WGT_W-1:0];
      e_w_r[2] <= w2_nxt[WGT_W-1:0];
      e_w_r[3] <= WGT_W'(d_cube_u_r);
      e_coef_r <= d_coef_r;
      e_sup_r  <= d_sup_r;
    end
  end

  // --------------------------------------------------------------------------
  // Stage F: coefficient times weight, exact in Q.32.
  // --------------------------------------------------------------------------
  prod_t f_prod_r [TAPS];
  logic  f_sup_r;

  always_ff @(posedge clk) begin
    if (en_f) begin
      for (int n = 0; n < TAPS; n++) begin
        f_prod_r[n] <= e_coef_r[n] * $signed({1'b0, e_w_r[n]});
      end
      f_sup_r <= e_sup_r;
    end
  end

  // --------------------------------------------------------------------------
  // Stage G: pairwise sums.
  // --------------------------------------------------------------------------
  logic signed [PROD_W:0] g_sum01_r;
  logic signed [PROD_W:0] g_sum23_r;
  logic                   g_sup_r;

  always_ff @(posedge clk) begin
    if (en_g) begin
      g_sum01_r <= (PROD_W+1)'(f_prod_r[0]) + (PROD_W+1)'(f_prod_r[1]);
      g_sum23_r <= (PROD_W+1)'(f_prod_r[2]) + (PROD_W+1)'(f_prod_r[3]);
      g_sup_r   <= f_sup_r;
    end
  end

  // --------------------------------------------------------------------------
  // Output stage: final sum, round half up to Q.16, saturate to 24 bits.
  // --------------------------------------------------------------------------
  logic signed [PROD_W+2:0]  sum_nxt;
  logic signed [PROD_W-14:0] rnd_nxt;
  logic [23:0]               val_nxt;
  logic [23:0]               o_val_r;
  logic                      o_sup_r;

  assign sum_nxt = (PROD_W+3)'(g_sum01_r) + (PROD_W+3)'(g_sum23_r)
                 + (PROD_W+3)'(32768);
  assign rnd_nxt = sum_nxt[PROD_W+2:16];

  always_comb begin
    if (rnd_nxt > $signed((PROD_W-13)'(8388607))) begin
      val_nxt = SAT_MAX;
    end else if (rnd_nxt < -$signed((PROD_W-13)'(8388608))) begin
      val_nxt = SAT_MIN;
    end else begin
      val_nxt = rnd_nxt[23:0];
    end
  end

  always_ff @(posedge clk) begin
    if (en_o) begin
      o_val_r <= val_nxt;
      o_sup_r <= g_sup_r;
    end
  end

  assign out_tvalid   = o_v_r;
  assign out_tdata    = o_val_r;
  assign out_tuser[0] = o_sup_r;

  // --------------------------------------------------------------------------
  // Assertions.
  // --------------------------------------------------------------------------
  logic [21:0] wsum;

  assign wsum = 22'(e_w_r[0]) + 22'(e_w_r[1]) + 22'(e_w_r[2]) + 22'(e_w_r[3]);

  // An empty output register lets every stage advance.
  a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !o_v_r |-> in_tready)
    else $error("input stalled with an empty output register");

  // The weights sum to six in Q.16, up to the truncation of squares and cubes.
  a_weight_sum: assert property (@(posedge clk) disable iff (!rst_n)
    e_v_r |-> ((wsum >= 22'd393208) && (wsum <= 22'd393224)))
    else $error("basis weights do not sum to six");

  // A point outside the support sees only zero weights or zero coefficients.
  a_zero_outside: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tuser[0]) |-> (out_tdata == 24'd0))
    else $error("nonzero value outside the support");

  // A result only appears when an evaluate beat left stage G.
  a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(o_v_r) |-> $past(g_v_r))
    else $error("result without an evaluate beat");

endmodule : cubic_bspline_evaluator
`default_nettype wire
